// ===== hdl/sctk_pkg.sv =====
// Package: shared constants, result type and character ROMs for the scancode decoder.
`timescale 1ns / 1ps

package sctk_pkg;

   // Field widths
   localparam int unsigned SCAN_W = 8;
   localparam int unsigned KIND_W = 3;
   localparam int unsigned CHAR_W = 7;
   localparam int unsigned NAV_W  = 3;
   localparam int unsigned MOD_W  = 2;

   // Event kinds
   localparam logic [KIND_W-1:0] KIND_NONE   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_CHAR   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_NAV    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_WORD   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_CANCEL = 3'd5;
   localparam logic [KIND_W-1:0] KIND_COMBO  = 3'd6;

   // Navigation codes
   localparam logic [NAV_W-1:0] NAV_NONE  = 3'd0;
   localparam logic [NAV_W-1:0] NAV_UP    = 3'd1;
   localparam logic [NAV_W-1:0] NAV_DOWN  = 3'd2;
   localparam logic [NAV_W-1:0] NAV_LEFT  = 3'd3;
   localparam logic [NAV_W-1:0] NAV_RIGHT = 3'd4;

   // Held modifier codes
   localparam logic [MOD_W-1:0] MOD_NONE  = 2'd0;
   localparam logic [MOD_W-1:0] MOD_CTRL  = 2'd1;
   localparam logic [MOD_W-1:0] MOD_SHIFT = 2'd2;
   localparam logic [MOD_W-1:0] MOD_ALT   = 2'd3;

   // Key numbers (low seven bits of a scancode)
   localparam logic [6:0] KEY_NULL  = 7'd0;
   localparam logic [6:0] KEY_BKSP  = 7'd14;
   localparam logic [6:0] KEY_CTRL  = 7'd29;
   localparam logic [6:0] KEY_L     = 7'd38;
   localparam logic [6:0] KEY_SHIFT = 7'd42;
   localparam logic [6:0] KEY_C     = 7'd46;
   localparam logic [6:0] KEY_ALT   = 7'd56;
   localparam logic [6:0] KEY_LAST  = 7'd58;
   localparam logic [6:0] KEY_UP    = 7'd72;
   localparam logic [6:0] KEY_LEFT  = 7'd75;
   localparam logic [6:0] KEY_RIGHT = 7'd77;
   localparam logic [6:0] KEY_DOWN  = 7'd80;

   // One result item
   typedef struct packed {
      logic [KIND_W-1:0] event_kind;
      logic [CHAR_W-1:0] char_code;
      logic [NAV_W-1:0]  nav_code;
   } rsp_payload_type;

   // Unshifted character ROM, keys 0..58
   function automatic logic [CHAR_W-1:0] plain_char(input logic [5:0] key);
      logic [CHAR_W-1:0] ch;
      unique case (key)
         6'd2:  ch = 7'h31;  6'd3:  ch = 7'h32;  6'd4:  ch = 7'h33;  6'd5:  ch = 7'h34;
         6'd6:  ch = 7'h35;  6'd7:  ch = 7'h36;  6'd8:  ch = 7'h37;  6'd9:  ch = 7'h38;
         6'd10: ch = 7'h39;  6'd11: ch = 7'h30;  6'd12: ch = 7'h2D;  6'd13: ch = 7'h3D;
         6'd14: ch = 7'h08;  6'd15: ch = 7'h09;  6'd16: ch = 7'h71;  6'd17: ch = 7'h77;
         6'd18: ch = 7'h65;  6'd19: ch = 7'h72;  6'd20: ch = 7'h74;  6'd21: ch = 7'h79;
         6'd22: ch = 7'h75;  6'd23: ch = 7'h69;  6'd24: ch = 7'h6F;  6'd25: ch = 7'h70;
         6'd26: ch = 7'h5B;  6'd27: ch = 7'h5D;  6'd28: ch = 7'h0A;  6'd30: ch = 7'h61;
         6'd31: ch = 7'h73;  6'd32: ch = 7'h64;  6'd33: ch = 7'h66;  6'd34: ch = 7'h67;
         6'd35: ch = 7'h68;  6'd36: ch = 7'h6A;  6'd37: ch = 7'h6B;  6'd38: ch = 7'h6C;
         6'd39: ch = 7'h3B;  6'd40: ch = 7'h27;  6'd41: ch = 7'h60;  6'd43: ch = 7'h5C;
         6'd44: ch = 7'h7A;  6'd45: ch = 7'h78;  6'd46: ch = 7'h63;  6'd47: ch = 7'h76;
         6'd48: ch = 7'h62;  6'd49: ch = 7'h6E;  6'd50: ch = 7'h6D;  6'd51: ch = 7'h2C;
         6'd52: ch = 7'h2E;  6'd53: ch = 7'h2F;  6'd55: ch = 7'h2A;  6'd57: ch = 7'h20;
         default: ch = '0;
      endcase
      return ch;
   endfunction

   // Shifted character ROM, keys 0..58
   function automatic logic [CHAR_W-1:0] shift_char(input logic [5:0] key);
      logic [CHAR_W-1:0] ch;
      unique case (key)
         6'd2:  ch = 7'h21;  6'd3:  ch = 7'h40;  6'd4:  ch = 7'h23;  6'd5:  ch = 7'h24;
         6'd6:  ch = 7'h25;  6'd7:  ch = 7'h5E;  6'd8:  ch = 7'h26;  6'd9:  ch = 7'h2A;
         6'd10: ch = 7'h28;  6'd11: ch = 7'h29;  6'd12: ch = 7'h5F;  6'd13: ch = 7'h2B;
         6'd16: ch = 7'h51;  6'd17: ch = 7'h57;  6'd18: ch = 7'h45;  6'd19: ch = 7'h52;
         6'd20: ch = 7'h54;  6'd21: ch = 7'h59;  6'd22: ch = 7'h55;  6'd23: ch = 7'h49;
         6'd24: ch = 7'h4F;  6'd25: ch = 7'h50;  6'd26: ch = 7'h7B;  6'd27: ch = 7'h7D;
         6'd30: ch = 7'h41;  6'd31: ch = 7'h53;  6'd32: ch = 7'h44;  6'd33: ch = 7'h46;
         6'd34: ch = 7'h47;  6'd35: ch = 7'h48;  6'd36: ch = 7'h4A;  6'd37: ch = 7'h4B;
         6'd38: ch = 7'h4C;  6'd39: ch = 7'h3A;  6'd40: ch = 7'h22;  6'd41: ch = 7'h7E;
         6'd43: ch = 7'h7C;  6'd44: ch = 7'h5A;  6'd45: ch = 7'h58;  6'd46: ch = 7'h43;
         6'd47: ch = 7'h56;  6'd48: ch = 7'h42;  6'd49: ch = 7'h4E;  6'd50: ch = 7'h4D;
         6'd51: ch = 7'h3C;  6'd52: ch = 7'h3E;  6'd53: ch = 7'h3F;  6'd55: ch = 7'h2A;
         6'd57: ch = 7'h20;
         default: ch = '0;
      endcase
      return ch;
   endfunction

endpackage

// ===== hdl/sctk_if.sv =====
// Interfaces: scancode request channel and key event response channel.
`timescale 1ns / 1ps

interface sctk_req_if
   import sctk_pkg::*;
;
   logic              valid;
   logic              ready;
   logic [SCAN_W-1:0] scan_code;

   modport source (output valid, output scan_code, input ready);
   modport sink   (input valid, input scan_code, output ready);
endinterface

interface sctk_rsp_if
   import sctk_pkg::*;
;
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] event_kind;
   logic [CHAR_W-1:0] char_code;
   logic [NAV_W-1:0]  nav_code;

   modport source (output valid, output event_kind, output char_code, output nav_code,
                   input ready);
   modport sink   (input valid, input event_kind, input char_code, input nav_code,
                   output ready);
endinterface

// ===== hdl/scancode_to_key_event_decoder.sv =====
// Top level: set-1 scancode to key event decoder with one held modifier.
//
//   Channel  Dir  Payload                              Transfer
//   req_if   in   scan_code[7:0]                       valid & ready
//   rsp_if   out  event_kind[2:0] char_code nav_code   valid & ready
//
// Two register stages: a scancode register, then the event register. A request passes
// through both registers before its response is valid; one item per cycle sustained
// while rsp_if.ready is high. The held modifier register updates when an item leaves
// the scancode register, so items see it strictly in order. Synchronous reset clears
// valids and sets the modifier to none. A stalled response holds the event register
// and a full scancode register; req_if.ready follows rsp_if.ready through one gate.
`timescale 1ns / 1ps

module scancode_to_key_event_decoder
   import sctk_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   sctk_req_if.sink          req_if,
   sctk_rsp_if.source        rsp_if
);

   logic              in_valid_ff;
   logic [SCAN_W-1:0] in_code_ff;
   logic              out_valid_ff;
   rsp_payload_type   out_data_ff;
   rsp_payload_type   out_data_in;
   logic [MOD_W-1:0]  mod_ff;
   logic [MOD_W-1:0]  mod_in;

   logic              advance;
   logic              req_fire;
   logic              step;
   logic [6:0]        key;
   logic              is_release;
   logic              is_mod_key;
   logic              in_rom;

   // Handshake: each stage moves when the one after it has room
   assign advance      = !out_valid_ff || rsp_if.ready;
   assign req_if.ready = !in_valid_ff || advance;
   assign req_fire     = req_if.valid && req_if.ready;
   assign step         = in_valid_ff && advance;

   // Scancode register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
      if (req_fire) begin
         in_code_ff <= req_if.scan_code;
      end
   end

   // Key decode
   assign key        = in_code_ff[6:0];
   assign is_release = in_code_ff[7];
   assign is_mod_key = (key == KEY_NULL) || (key == KEY_CTRL) ||
                       (key == KEY_SHIFT) || (key == KEY_ALT);
   assign in_rom     = !is_release && (key <= KEY_LAST);

   // Event and next modifier
   always_comb begin
      out_data_in = '{event_kind: KIND_NONE, char_code: '0, nav_code: NAV_NONE};
      mod_in      = mod_ff;
      if (is_release) begin
         if (is_mod_key) begin
            mod_in = MOD_NONE;
         end
      end else begin
         unique case (mod_ff)
            MOD_NONE: begin
               if (is_mod_key) begin
                  if (key == KEY_CTRL) begin
                     mod_in = MOD_CTRL;
                  end else if (key == KEY_SHIFT) begin
                     mod_in = MOD_SHIFT;
                  end else if (key == KEY_ALT) begin
                     mod_in = MOD_ALT;
                  end
               end else if (in_rom) begin
                  out_data_in.event_kind = KIND_CHAR;
                  out_data_in.char_code  = plain_char(key[5:0]);
               end else begin
                  unique case (key)
                     KEY_UP: begin
                        out_data_in.event_kind = KIND_NAV;
                        out_data_in.nav_code   = NAV_UP;
                     end
                     KEY_DOWN: begin
                        out_data_in.event_kind = KIND_NAV;
                        out_data_in.nav_code   = NAV_DOWN;
                     end
                     KEY_LEFT: begin
                        out_data_in.event_kind = KIND_NAV;
                        out_data_in.nav_code   = NAV_LEFT;
                     end
                     KEY_RIGHT: begin
                        out_data_in.event_kind = KIND_NAV;
                        out_data_in.nav_code   = NAV_RIGHT;
                     end
                     default: ;
                  endcase
               end
            end
            MOD_CTRL: begin
               mod_in = MOD_NONE;
               if (key == KEY_L) begin
                  out_data_in.event_kind = KIND_CLEAR;
               end else if (key == KEY_C) begin
                  out_data_in.event_kind = KIND_CANCEL;
               end else if (in_rom) begin
                  // empty ROM slot gives no combo
                  out_data_in.char_code  = plain_char(key[5:0]);
                  out_data_in.event_kind = (out_data_in.char_code != '0) ? KIND_COMBO
                                                                         : KIND_NONE;
               end
            end
            MOD_SHIFT: begin
               if (in_rom) begin
                  out_data_in.event_kind = KIND_CHAR;
                  out_data_in.char_code  = shift_char(key[5:0]);
               end else begin
                  mod_in = MOD_NONE;
               end
            end
            MOD_ALT: begin
               mod_in = MOD_NONE;
               if (key == KEY_BKSP) begin
                  out_data_in.event_kind = KIND_WORD;
               end
            end
         endcase
      end
   end

   // Event register and modifier state
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         mod_ff       <= MOD_NONE;
      end else begin
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
         if (step) begin
            mod_ff <= mod_in;
         end
      end
      if (step) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.event_kind = out_data_ff.event_kind;
   assign rsp_if.char_code  = out_data_ff.char_code;
   assign rsp_if.nav_code   = out_data_ff.nav_code;

`ifndef SYNTH
   // a modifier release always drops the held modifier
   a_release_clears: assert property (@(posedge clock) disable iff (reset)
      (step && is_release && is_mod_key) |=> (mod_ff == MOD_NONE))
      else $error("modifier not cleared after release");

   // a release never produces an event
   a_release_quiet: assert property (@(posedge clock) disable iff (reset)
      (step && is_release) |=> (out_data_ff.event_kind == KIND_NONE))
      else $error("release produced an event");

   // shift stays held across shifted characters
   a_shift_sticks: assert property (@(posedge clock) disable iff (reset)
      (step && (mod_ff == MOD_SHIFT) && in_rom) |=> (mod_ff == MOD_SHIFT))
      else $error("shift dropped on shifted character");

   // nav code present exactly for navigation events
   a_nav_match: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> ((out_data_ff.event_kind == KIND_NAV) ==
                        (out_data_ff.nav_code != NAV_NONE)))
      else $error("nav code and event kind disagree");

   // character code only on char and combo events
   a_char_kind: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_data_ff.char_code != '0)) |->
         ((out_data_ff.event_kind == KIND_CHAR) || (out_data_ff.event_kind == KIND_COMBO)))
      else $error("char code on wrong event kind");
`endif

endmodule

// ===== sim/scancode_to_key_event_decoder_tb.sv =====
// Testbench: scancode decoder checked against a cycle-free key event predictor.
`timescale 1ns / 1ps

import sctk_pkg::*;

// Predicts key events from accepted scancodes and checks returned events in order
class key_event_scoreboard;
   logic [MOD_W-1:0]  held_mod;
   logic [CHAR_W-1:0] plain_keys [0:58];
   logic [CHAR_W-1:0] upper_keys [0:58];
   rsp_payload_type   pending_events [$];
   int unsigned       failures;

   function new();
      held_mod   = MOD_NONE;
      failures   = 0;
      plain_keys = '{
         7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
         7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
         7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
         7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
         7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
         7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00};
      upper_keys = '{
         7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
         7'h28, 7'h29, 7'h5F, 7'h2B, 7'h00, 7'h00, 7'h51, 7'h57, 7'h45, 7'h52,
         7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h00, 7'h00,
         7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
         7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
         7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00};
   endfunction

   function void report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      failures++;
   endfunction

   // Decode one scancode and advance the held modifier
   function rsp_payload_type decode_scan(logic [SCAN_W-1:0] code);
      rsp_payload_type ev;
      logic [6:0]      key;
      logic            mod_key;
      key     = code[6:0];
      mod_key = (key == KEY_NULL) || (key == KEY_CTRL) || (key == KEY_SHIFT) ||
                (key == KEY_ALT);
      ev.event_kind = KIND_NONE;
      ev.char_code  = '0;
      ev.nav_code   = NAV_NONE;
      if (code[7]) begin
         // releases only drop the modifier
         if (mod_key) held_mod = MOD_NONE;
      end else if (held_mod == MOD_NONE && mod_key) begin
         if (key == KEY_CTRL)       held_mod = MOD_CTRL;
         else if (key == KEY_SHIFT) held_mod = MOD_SHIFT;
         else if (key == KEY_ALT)   held_mod = MOD_ALT;
      end else if (held_mod == MOD_CTRL) begin
         if (key == KEY_L) ev.event_kind = KIND_CLEAR;
         else if (key == KEY_C) ev.event_kind = KIND_CANCEL;
         else if (key <= KEY_LAST) begin
            ev.char_code  = plain_keys[key];
            ev.event_kind = (ev.char_code != 0) ? KIND_COMBO : KIND_NONE;
         end
         held_mod = MOD_NONE;
      end else if (held_mod == MOD_ALT && key == KEY_BKSP) begin
         ev.event_kind = KIND_WORD;
         held_mod      = MOD_NONE;
      end else if (held_mod == MOD_SHIFT && key <= KEY_LAST) begin
         // shift stays held across characters
         ev.event_kind = KIND_CHAR;
         ev.char_code  = upper_keys[key];
      end else if (held_mod == MOD_NONE && key <= KEY_LAST) begin
         ev.event_kind = KIND_CHAR;
         ev.char_code  = plain_keys[key];
      end else if (held_mod == MOD_NONE && key == KEY_UP) begin
         ev.event_kind = KIND_NAV;
         ev.nav_code   = NAV_UP;
      end else if (held_mod == MOD_NONE && key == KEY_DOWN) begin
         ev.event_kind = KIND_NAV;
         ev.nav_code   = NAV_DOWN;
      end else if (held_mod == MOD_NONE && key == KEY_LEFT) begin
         ev.event_kind = KIND_NAV;
         ev.nav_code   = NAV_LEFT;
      end else if (held_mod == MOD_NONE && key == KEY_RIGHT) begin
         ev.event_kind = KIND_NAV;
         ev.nav_code   = NAV_RIGHT;
      end else begin
         held_mod = MOD_NONE;
      end
      return ev;
   endfunction

   function void note_scan(logic [SCAN_W-1:0] code);
      pending_events.push_back(decode_scan(code));
   endfunction

   function void check_event(rsp_payload_type got);
      rsp_payload_type want;
      if (pending_events.size() == 0) begin
         report($sformatf("unexpected event kind=%0d char=%0h nav=%0d",
                          got.event_kind, got.char_code, got.nav_code));
         return;
      end
      want = pending_events.pop_front();
      if (got.event_kind !== want.event_kind)
         report($sformatf("event_kind got %0d want %0d", got.event_kind, want.event_kind));
      if (got.char_code !== want.char_code)
         report($sformatf("char_code got %0h want %0h", got.char_code, want.char_code));
      if (got.nav_code !== want.nav_code)
         report($sformatf("nav_code got %0d want %0d", got.nav_code, want.nav_code));
   endfunction

   function int pending();
      return pending_events.size();
   endfunction
endclass

module scancode_to_key_event_decoder_tb;
   import sctk_pkg::*;

   localparam int unsigned HOLD_CYCLES  = 80;
   localparam int unsigned STALL_LIMIT  = 3000;
   localparam int unsigned PHASE_ITEMS  = 320;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sctk_req_if req_ch ();
   sctk_rsp_if rsp_ch ();

   scancode_to_key_event_decoder dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   key_event_scoreboard board = new();

   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned scans_sent = 0;
   bit          hold_req = 1'b0;
   int unsigned quiet_cycles = 0;

   always #6 clock = ~clock;

   // Watchdog: too long without any transfer ends the run
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("scancode_to_key_event_decoder regression: fail");
            $finish;
         end
      end
   end

   // Response side: check at the rising edge, pick ready at the falling edge
   initial begin
      rsp_payload_type got;
      int unsigned     hold_count;
      hold_count   = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            got.event_kind = rsp_ch.event_kind;
            got.char_code  = rsp_ch.char_code;
            got.nav_code   = rsp_ch.nav_code;
            board.check_event(got);
         end
         @(negedge clock);
         if (hold_req && hold_count < HOLD_CYCLES) begin
            // long back-pressure stretch
            rsp_ch.ready <= 1'b0;
            hold_count++;
         end else begin
            if (hold_req) begin
               hold_req   = 1'b0;
               hold_count = 0;
            end
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Offer one scancode; entered and left at a falling edge with valid still high
   task automatic send_code(input logic [SCAN_W-1:0] code);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid     <= 1'b0;
         req_ch.scan_code <= SCAN_W'($urandom_range(255));
         @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.scan_code <= code;
      do @(posedge clock); while (!req_ch.ready);
      board.note_scan(code);
      scans_sent++;
      @(negedge clock);
   endtask

   // Drop valid and wait for every predicted event to come back
   task automatic drain_events();
      req_ch.valid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
   endtask

   task automatic send_mod_key(input int unsigned which, input bit release_it);
      logic [6:0] key;
      case (which)
         0:       key = KEY_CTRL;
         1:       key = KEY_SHIFT;
         2:       key = KEY_ALT;
         default: key = KEY_NULL;
      endcase
      send_code({release_it, key});
   endtask

   // One random group: mostly modifier sequences and keys, some noise
   task automatic send_random_group();
      int unsigned pick;
      int unsigned which;
      pick  = $urandom_range(99);
      which = $urandom_range(3);
      if (pick < 35) begin
         send_code(SCAN_W'($urandom_range(58)));
      end else if (pick < 60) begin
         send_mod_key(which, 1'b0);
         case ($urandom_range(5))
            0:       send_code({1'b0, KEY_L});
            1:       send_code({1'b0, KEY_C});
            2:       send_code({1'b0, KEY_BKSP});
            3:       send_code(SCAN_W'($urandom_range(127)));
            default: send_code(SCAN_W'($urandom_range(58)));
         endcase
         repeat ($urandom_range(2)) send_code(SCAN_W'($urandom_range(58)));
      end else if (pick < 70) begin
         case ($urandom_range(3))
            0:       send_code({1'b0, KEY_UP});
            1:       send_code({1'b0, KEY_DOWN});
            2:       send_code({1'b0, KEY_LEFT});
            default: send_code({1'b0, KEY_RIGHT});
         endcase
      end else if (pick < 80) begin
         if ($urandom_range(1)) send_mod_key(which, 1'b1);
         else send_code(SCAN_W'($urandom_range(255, 128)));
      end else begin
         send_code(SCAN_W'($urandom_range(255)));
      end
   endtask

   // Main sequence
   initial begin
      logic [SCAN_W-1:0] directed [$];
      int unsigned       target;
      int unsigned       phase_start;
      bit                hold_done;
      bit                drain_done;
      hold_done          = 1'b0;
      drain_done         = 1'b0;
      req_ch.valid       = 1'b0;
      req_ch.scan_code   = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: field extremes, navigation, every modifier path
      directed = '{8'h00, 8'hFF, 8'h7F, 8'h80, 8'h10, 8'h48, 8'h50, 8'h4B, 8'h4D,
                   8'h1D, 8'h26, 8'h1D, 8'h2E, 8'h1D, 8'h1E, 8'h1D, 8'h01,
                   8'h2A, 8'h10, 8'hAA, 8'h38, 8'h0E, 8'h38, 8'h10, 8'h2A, 8'h5A};
      foreach (directed[i]) send_code(directed[i]);

      // Random phases with different idle mixes
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 82; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 82; end
            default: begin send_idle_pct = 16; recv_stall_pct = 16; end
         endcase
         phase_start = scans_sent;
         target      = scans_sent + PHASE_ITEMS;
         while (scans_sent < target) begin
            if (!hold_done && phase == 0 && scans_sent > phase_start + 100) begin
               hold_req  = 1'b1;
               hold_done = 1'b1;
            end
            if (!drain_done && phase == 1 && scans_sent > phase_start + 150) begin
               drain_events();
               drain_done = 1'b1;
            end
            send_random_group();
         end
      end

      drain_events();
      repeat (8) @(negedge clock);
      if (board.pending() != 0)
         board.report($sformatf("%0d events never returned", board.pending()));
      if (board.failures == 0) begin
         $display("scancode_to_key_event_decoder regression: pass");
      end else begin
         $display("scancode_to_key_event_decoder regression: fail");
      end
      $finish;
   end

endmodule
